FILE: design/tlf_pkg.sv
// Shared types and constants for the text line folder.
// Used by tlf_ctrl, tlf_datapath and text_line_folder; depends on nothing.
`default_nettype none

package tlf_pkg;

	localparam int HOLD_DEPTH = 16;
	localparam int RUN_LIMIT  = (HOLD_DEPTH < 16) ? HOLD_DEPTH : 16;
	localparam int CNT_W      = $clog2(RUN_LIMIT + 1);
	localparam int IDX_W      = $clog2(RUN_LIMIT);

	localparam logic [7:0] CH_NL     = 8'd10;
	localparam logic [7:0] CH_SP     = 8'd32;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_HYPHEN = 8'd45;

	localparam logic [7:0] LINE_WIDTH_RST   = 8'd80;
	localparam logic [3:0] BLANK_WINDOW_RST = 4'd10;

	localparam logic REG_LINE_WIDTH   = 1'b0;
	localparam logic REG_BLANK_WINDOW = 1'b1;

	typedef struct packed {
		logic [7:0] char_in;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       last_of_run;
	} out_item_t;

	typedef enum logic [1:0] {
		SEL_DRAIN,
		SEL_TAIL0,
		SEL_TAIL1
	} emit_sel_t;

	typedef struct packed {
		logic      accept;
		logic      emit;
		emit_sel_t sel;
		logic      last;
	} tlf_cmd_t;

	typedef struct packed {
		logic       slot_free;
		logic       plan_drain_nz;
		logic [1:0] plan_tail_len;
		logic       drain_last;
		logic [1:0] tail_len;
	} tlf_sts_t;

endpackage

`default_nettype wire

FILE: design/text_line_folder.sv
// Top level of the text line folder: joins controller and datapath.
// Depends on tlf_pkg, tlf_ctrl and tlf_datapath.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-----------------------------------
//   in      | input     | in_valid/in_stall  | in_data  (char_in, end_of_text)
//   out     | output    | out_valid/out_stall| out_data (char_out, last_of_run)
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// An item is taken while the controller is idle; its results then go one at a time through
// the output sequencer (held run first, then the tail), and a plain passed-through character
// has one result. A folded run drains up to 18 results.
// Reset restores line_width 80, blank_window 10 and an empty hold run.
// An output stall freezes the sequencer; input is stalled until all results are issued.
`default_nettype none

module text_line_folder (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire tlf_pkg::in_item_t  in_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output tlf_pkg::out_item_t      out_data,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [7:0]         cfg_data
);

	tlf_pkg::tlf_cmd_t cmd;
	tlf_pkg::tlf_sts_t sts;

	tlf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlf_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

`default_nettype wire

FILE: design/tlf_ctrl.sv
// Controller state machine of the text line folder.
// Depends on tlf_pkg; drives commands to tlf_datapath and reads its status.
`default_nettype none

module tlf_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	input  wire tlf_pkg::tlf_sts_t sts,
	output tlf_pkg::tlf_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DRAIN,
		ST_TAIL0,
		ST_TAIL1
	} state_t;

	state_t state_q;

	always_comb begin
		in_stall   = (state_q != ST_IDLE);
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.emit   = 1'b0;
		cmd.sel    = tlf_pkg::SEL_DRAIN;
		cmd.last   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				cmd.emit = 1'b0;
			end
			ST_DRAIN: begin
				cmd.emit = sts.slot_free;
				cmd.sel  = tlf_pkg::SEL_DRAIN;
				cmd.last = sts.drain_last && (sts.tail_len == 2'd0);
			end
			ST_TAIL0: begin
				cmd.emit = sts.slot_free;
				cmd.sel  = tlf_pkg::SEL_TAIL0;
				cmd.last = (sts.tail_len == 2'd1);
			end
			ST_TAIL1: begin
				cmd.emit = sts.slot_free;
				cmd.sel  = tlf_pkg::SEL_TAIL1;
				cmd.last = 1'b1;
			end
			default: begin
				cmd.emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept) begin
						if (sts.plan_drain_nz) begin
							state_q <= ST_DRAIN;
						end else if (sts.plan_tail_len != 2'd0) begin
							state_q <= ST_TAIL0;
						end
					end
				end
				ST_DRAIN: begin
					if (cmd.emit && sts.drain_last) begin
						state_q <= (sts.tail_len != 2'd0) ? ST_TAIL0 : ST_IDLE;
					end
				end
				ST_TAIL0: begin
					if (cmd.emit) begin
						state_q <= (sts.tail_len == 2'd2) ? ST_TAIL1 : ST_IDLE;
					end
				end
				ST_TAIL1: begin
					if (cmd.emit) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_emit_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.slot_free)
		else $error("emit issued while the output register is occupied");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && cmd.last |=> state_q == ST_IDLE)
		else $error("controller did not return to idle after the final result");

	a_empty_plan_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept && !sts.plan_drain_nz && (sts.plan_tail_len == 2'd0)
		|=> state_q == ST_IDLE)
		else $error("controller left idle for an item without results");
`endif

endmodule

`default_nettype wire

FILE: design/tlf_datapath.sv
// Datapath of the text line folder: registers, fold state, hold buffer, output register.
// Depends on tlf_pkg; commanded by tlf_ctrl.
`default_nettype none

module tlf_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tlf_pkg::in_item_t  in_data,
	output tlf_pkg::out_item_t      out_data,
	output logic                    out_valid,
	input  wire logic               out_stall,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic               cfg_index,
	input  wire logic [7:0]         cfg_data,
	input  wire tlf_pkg::tlf_cmd_t  cmd,
	output tlf_pkg::tlf_sts_t       sts
);

	localparam int CNT_W = tlf_pkg::CNT_W;
	localparam int IDX_W = tlf_pkg::IDX_W;

	logic [7:0]       lw_q;
	logic [3:0]       bw_q;
	logic [7:0]       col_q;
	logic             holding_q;
	logic [CNT_W-1:0] hold_count_q;
	logic [IDX_W-1:0] blank_pos_q;
	logic             blank_seen_q;
	logic [7:0]       buf_q [tlf_pkg::RUN_LIMIT];

	logic [CNT_W-1:0] drain_len_q;
	logic [CNT_W-1:0] drain_idx_q;
	logic             repl_q;
	logic [IDX_W-1:0] repl_pos_q;
	logic [7:0]       tail0_q;
	logic [7:0]       tail1_q;
	logic [1:0]       tail_len_q;

	tlf_pkg::out_item_t out_q;
	logic               out_valid_q;

	logic [7:0]       ch;
	logic [7:0]       start;
	logic [7:0]       col_inc;
	logic             hold_now;
	logic             is_blank;
	logic [CNT_W-1:0] cnt1;
	logic             seen1;
	logic [IDX_W-1:0] pos1;
	logic             fold;
	logic [CNT_W-1:0] after_blank;
	logic [CNT_W-1:0] p_drain;
	logic             p_repl;
	logic [7:0]       p_tail0;
	logic [7:0]       p_tail1;
	logic [1:0]       p_tlen;
	logic [7:0]       n_col;
	logic             n_holding;
	logic [CNT_W-1:0] n_cnt;
	logic [IDX_W-1:0] n_pos;
	logic             n_seen;
	logic             buf_we;
	logic             slot_free;
	logic [7:0]       emit_ch;

	always_comb begin
		ch          = in_data.char_in;
		start       = (lw_q > {4'b0, bw_q}) ? (lw_q - {4'b0, bw_q}) : 8'd0;
		col_inc     = (col_q == 8'hFF) ? col_q : (col_q + 8'd1);
		hold_now    = holding_q || (col_inc >= start);
		is_blank    = (ch == tlf_pkg::CH_SP) || (ch == tlf_pkg::CH_TAB);
		cnt1        = hold_count_q + CNT_W'(1);
		seen1       = blank_seen_q || is_blank;
		pos1        = is_blank ? hold_count_q[IDX_W-1:0] : blank_pos_q;
		fold        = (col_inc >= lw_q) || (cnt1 == CNT_W'(tlf_pkg::RUN_LIMIT));
		after_blank = cnt1 - CNT_W'(1) - CNT_W'(pos1);

		p_drain   = '0;
		p_repl    = 1'b0;
		p_tail0   = ch;
		p_tail1   = tlf_pkg::CH_NL;
		p_tlen    = 2'd0;
		n_col     = col_q;
		n_holding = holding_q;
		n_cnt     = hold_count_q;
		n_pos     = blank_pos_q;
		n_seen    = blank_seen_q;
		buf_we    = 1'b0;

		if (ch == tlf_pkg::CH_NL) begin
			p_drain   = hold_count_q;
			p_tail0   = tlf_pkg::CH_NL;
			p_tlen    = 2'd1;
			n_col     = 8'd1;
			n_holding = 1'b0;
			n_cnt     = '0;
			n_pos     = '0;
			n_seen    = 1'b0;
		end else if (!hold_now) begin
			p_tlen = 2'd1;
			n_col  = col_inc;
		end else begin
			buf_we = 1'b1;
			if (fold) begin
				p_drain   = cnt1;
				n_holding = 1'b0;
				n_cnt     = '0;
				n_pos     = '0;
				n_seen    = 1'b0;
				if (seen1) begin
					p_repl = 1'b1;
					n_col  = {{(8-CNT_W){1'b0}}, after_blank};
				end else begin
					p_tail0 = tlf_pkg::CH_HYPHEN;
					p_tlen  = 2'd2;
					n_col   = 8'd0;
				end
			end else begin
				n_holding = 1'b1;
				n_cnt     = cnt1;
				n_pos     = pos1;
				n_seen    = seen1;
				n_col     = col_inc;
				if (in_data.end_of_text) begin
					p_drain = cnt1;
				end
			end
		end

		if (in_data.end_of_text) begin
			n_col     = 8'd0;
			n_holding = 1'b0;
			n_cnt     = '0;
			n_pos     = '0;
			n_seen    = 1'b0;
		end
	end

	always_comb begin
		case (cmd.sel)
			tlf_pkg::SEL_DRAIN: begin
				emit_ch = (repl_q && (drain_idx_q[IDX_W-1:0] == repl_pos_q)) ?
					tlf_pkg::CH_NL : buf_q[drain_idx_q[IDX_W-1:0]];
			end
			tlf_pkg::SEL_TAIL0: begin
				emit_ch = tail0_q;
			end
			tlf_pkg::SEL_TAIL1: begin
				emit_ch = tail1_q;
			end
			default: begin
				emit_ch = tail1_q;
			end
		endcase
	end

	assign slot_free = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign out_data  = out_q;
	assign out_valid = out_valid_q;

	assign sts.slot_free     = slot_free;
	assign sts.plan_drain_nz = (p_drain != '0);
	assign sts.plan_tail_len = p_tlen;
	assign sts.drain_last    = ((drain_idx_q + CNT_W'(1)) == drain_len_q);
	assign sts.tail_len      = tail_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_q         <= tlf_pkg::LINE_WIDTH_RST;
			bw_q         <= tlf_pkg::BLANK_WINDOW_RST;
			col_q        <= 8'd0;
			holding_q    <= 1'b0;
			hold_count_q <= '0;
			blank_pos_q  <= '0;
			blank_seen_q <= 1'b0;
			drain_len_q  <= '0;
			drain_idx_q  <= '0;
			repl_q       <= 1'b0;
			tail_len_q   <= 2'd0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == tlf_pkg::REG_LINE_WIDTH) begin
					lw_q <= cfg_data;
				end else if (cfg_index == tlf_pkg::REG_BLANK_WINDOW) begin
					bw_q <= cfg_data[3:0];
				end
			end
			if (cmd.accept) begin
				col_q        <= n_col;
				holding_q    <= n_holding;
				hold_count_q <= n_cnt;
				blank_pos_q  <= n_pos;
				blank_seen_q <= n_seen;
				drain_len_q  <= p_drain;
				drain_idx_q  <= '0;
				repl_q       <= p_repl;
				tail_len_q   <= p_tlen;
			end else if (cmd.emit && (cmd.sel == tlf_pkg::SEL_DRAIN)) begin
				drain_idx_q <= drain_idx_q + CNT_W'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			repl_pos_q <= pos1;
			tail0_q    <= p_tail0;
			tail1_q    <= p_tail1;
		end
		if (cmd.emit) begin
			out_q.char_out    <= emit_ch;
			out_q.last_of_run <= cmd.last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && buf_we) begin
			buf_q[hold_count_q[IDX_W-1:0]] <= ch;
		end
	end

`ifndef ASSERT_OFF
	a_count_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		hold_count_q != CNT_W'(tlf_pkg::RUN_LIMIT))
		else $error("held run reached its limit without folding");

	a_idle_hold_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!holding_q |-> (hold_count_q == '0) && !blank_seen_q)
		else $error("hold state left over while not holding");

	a_drain_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && (cmd.sel == tlf_pkg::SEL_DRAIN) |-> drain_idx_q < drain_len_q)
		else $error("drain read past the held run");
`endif

endmodule

`default_nettype wire

FILE: tb/text_line_folder_tb.sv
// Testbench for text_line_folder: drives characters with random gaps and output stalls,
// predicts the folded text and checks every output transfer field by field.
// Depends on tlf_pkg and text_line_folder.
`default_nettype none

module text_line_folder_tb;

	localparam int SETTLE_CYCLES = 24;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	tlf_pkg::in_item_t    in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	tlf_pkg::out_item_t   out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic                 cfg_index = 1'b0;
	logic [7:0]           cfg_data = '0;

	int unsigned          fold_width;
	int unsigned          blank_span;
	int unsigned          column;
	int unsigned          run_len;
	int unsigned          blank_at;
	bit                   holding;
	bit                   blank_seen;
	logic [7:0]           held_chars [tlf_pkg::RUN_LIMIT];
	tlf_pkg::out_item_t   expected_text [$];
	int                   mismatch_count = 0;
	bit                   no_idle = 1'b0;
	bit                   long_hold_req = 1'b0;
	int                   stall_left = 0;

	text_line_folder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic void expect_char(input logic [7:0] c);
		expected_text.push_back('{char_out: c, last_of_run: 1'b0});
	endfunction

	function automatic void clear_held();
		holding = 1'b0;
		run_len = 0;
		blank_at = 0;
		blank_seen = 1'b0;
	endfunction

	function automatic void flush_held();
		for (int i = 0; i < run_len; i++)
			expect_char(held_chars[i]);
		clear_held();
	endfunction

	function automatic void fold_char(input tlf_pkg::in_item_t item);
		int unsigned        queued;
		int unsigned        start;
		tlf_pkg::out_item_t tail;
		queued = expected_text.size();
		if (item.char_in == tlf_pkg::CH_NL) begin
			flush_held();
			expect_char(tlf_pkg::CH_NL);
			column = 1;
		end else begin
			start = (fold_width > blank_span) ? fold_width - blank_span : 0;
			if (column < 255)
				column++;
			if (!holding && column >= start)
				holding = 1'b1;
			if (!holding) begin
				expect_char(item.char_in);
			end else begin
				if (run_len < tlf_pkg::RUN_LIMIT) begin
					if (item.char_in == tlf_pkg::CH_SP || item.char_in == tlf_pkg::CH_TAB) begin
						blank_at = run_len;
						blank_seen = 1'b1;
					end
					held_chars[run_len] = item.char_in;
					run_len++;
				end
				if (column >= fold_width || run_len >= tlf_pkg::RUN_LIMIT) begin
					if (blank_seen) begin
						for (int i = 0; i < run_len; i++)
							expect_char(i == blank_at ? tlf_pkg::CH_NL : held_chars[i]);
						column = run_len - 1 - blank_at;
						clear_held();
					end else begin
						flush_held();
						expect_char(tlf_pkg::CH_HYPHEN);
						expect_char(tlf_pkg::CH_NL);
						column = 0;
					end
				end
			end
		end
		if (item.end_of_text) begin
			flush_held();
			column = 0;
		end
		if (expected_text.size() > queued) begin
			tail = expected_text.pop_back();
			tail.last_of_run = 1'b1;
			expected_text.push_back(tail);
		end
	endfunction

	function automatic logic [7:0] random_glyph();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == tlf_pkg::CH_NL || c == tlf_pkg::CH_SP || c == tlf_pkg::CH_TAB);
		return c;
	endfunction

	task automatic send_item(input logic [7:0] c, input logic eot);
		tlf_pkg::in_item_t item;
		item = '{char_in: c, end_of_text: eot};
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (in_stall);
		fold_char(item);
		@(negedge clk);
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], 1'b0);
	endtask

	task automatic send_filler(input int count);
		repeat (count) send_item(random_glyph(), 1'b0);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_text.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (idx == tlf_pkg::REG_LINE_WIDTH)
			fold_width = {24'd0, value};
		else
			blank_span = {28'd0, value[3:0]};
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_fold(input logic [7:0] width, input logic [3:0] window);
		logic [3:0] junk;
		junk = 4'($urandom_range(0, 15));
		write_reg(tlf_pkg::REG_LINE_WIDTH, width);
		write_reg(tlf_pkg::REG_BLANK_WINDOW, {junk, window});
	endtask

	task automatic test_default_widths();
		send_filler(73);
		send_text(" ");
		send_filler(8);
		send_text("\n");
	endtask

	task automatic test_hyphen_fold();
		set_fold(8'd32, 4'd1);
		send_filler(34);
		send_text("\n");
	endtask

	task automatic test_newline_in_hold();
		set_fold(8'd32, 4'd15);
		send_filler(20);
		send_text(" x\n");
	endtask

	task automatic test_end_of_text();
		send_filler(25);
		send_item("q", 1'b1);
		send_item(tlf_pkg::CH_NL, 1'b1);
		send_item(tlf_pkg::CH_SP, 1'b1);
		send_item(8'h00, 1'b0);
		send_item(tlf_pkg::CH_TAB, 1'b0);
		send_item(8'hFF, 1'b1);
	endtask

	task automatic test_run_full();
		set_fold(8'd32, 4'd15);
		send_text("\n");
		send_filler(15);
		send_text(" ");
		send_filler(8);
		write_reg(tlf_pkg::REG_LINE_WIDTH, 8'd60);
		send_filler(7);
		send_text("\n");
	endtask

	task automatic test_fold_overdue();
		set_fold(8'd50, 4'd15);
		send_text("\n");
		send_filler(32);
		write_reg(tlf_pkg::REG_LINE_WIDTH, 8'd32);
		send_text("z\n");
	endtask

	task automatic test_window_covers_width();
		set_fold(8'd12, 4'd15);
		send_text("\nab cdefghijklmnopqrstu\n");
	endtask

	task automatic test_output_hold_off();
		set_fold(8'd32, 4'd8);
		long_hold_req = 1'b1;
		send_text("\nWords wait here while the output is held.\n");
	endtask

	task automatic test_random_text();
		int         sent;
		logic [7:0] width;
		logic [3:0] window;
		logic [7:0] c;
		sent = 0;
		while (sent < 32) begin
			if (sent >= 16)
				no_idle = 1'b1;
			width = ($urandom_range(0, 3) == 0) ? 8'd32 : 8'($urandom_range(32, 64));
			case ($urandom_range(0, 2))
				0: window = 4'd1;
				1: window = 4'd15;
				default: window = 4'($urandom_range(1, 15));
			endcase
			set_fold(width, window);
			repeat ($urandom_range(16, 24)) begin
				case ($urandom_range(0, 59))
					0: c = tlf_pkg::CH_NL;
					1, 2, 3, 4: c = tlf_pkg::CH_SP;
					5, 6, 7, 8, 9: c = tlf_pkg::CH_TAB;
					10, 11, 12: c = 8'($urandom_range(0, 255));
					default: c = random_glyph();
				endcase
				send_item(c, $urandom_range(0, 79) == 0);
				sent++;
			end
		end
	endtask

	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			stall_left = 399;
			out_stall <= 1'b1;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 8);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic note_mismatch(input string what, input tlf_pkg::out_item_t want,
		input tlf_pkg::out_item_t got);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("mismatch on %s: expected char %h last %b, got char %h last %b",
				what, want.char_out, want.last_of_run, got.char_out, got.last_of_run);
	endtask

	always @(posedge clk) begin : check_output
		tlf_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_text.size() == 0) begin
				note_mismatch("unexpected transfer", '0, out_data);
			end else begin
				want = expected_text.pop_front();
				if (out_data.char_out !== want.char_out)
					note_mismatch("char_out", want, out_data);
				if (out_data.last_of_run !== want.last_of_run)
					note_mismatch("last_of_run", want, out_data);
			end
		end
	end

	initial begin
		fold_width = {24'd0, tlf_pkg::LINE_WIDTH_RST};
		blank_span = {28'd0, tlf_pkg::BLANK_WINDOW_RST};
		column = 0;
		clear_held();
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_default_widths();
		test_hyphen_fold();
		test_newline_in_hold();
		test_end_of_text();
		test_run_full();
		test_fold_overdue();
		test_window_covers_width();
		test_output_hold_off();
		test_random_text();
		wait_drained();
		if (mismatch_count == 0)
			$display("text_line_folder_tb passed");
		else
			$display("text_line_folder_tb failed");
		$finish;
	end

	initial begin
		#16000000;
		$display("text_line_folder_tb failed");
		$finish;
	end

endmodule

`default_nettype wire
